// File: hw/rtl/fipc_pkg.sv
// Package: shared constants, types and register indexes for the impulse profile block.
package fipc_pkg;

	localparam int POS_BITS_DEF = 24;
	localparam int QUAT_BITS_DEF = 16;
	localparam int COEF_FRAC_BITS_DEF = 16;
	localparam int AXES = 6;
	localparam int TGT_BITS = 16;
	localparam int TIME_BITS = 32;
	localparam int LIM_BITS = 52;
	localparam int COS_BITS = 15;
	localparam int PACK_BITS = 48;
	localparam int IDX_BITS = 3;

	typedef enum logic [IDX_BITS-1:0] {
		REG_RUN    = 3'd0,
		REG_RAMP   = 3'd1,
		REG_TLIM   = 3'd2,
		REG_RCOS   = 3'd3,
		REG_FORCE  = 3'd4,
		REG_TORQUE = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SCALE,
		ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic check;
		logic div_start;
		logic div_step;
		logic scale_step;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_done;
		logic scale_done;
	} status_t;

endpackage

// File: hw/rtl/fipc_if.sv
// Interfaces: input item channel, result channel and configuration write channel.
interface fipc_in_if #(
	parameter int POS_BITS = fipc_pkg::POS_BITS_DEF,
	parameter int QUAT_BITS = fipc_pkg::QUAT_BITS_DEF
);
	logic valid;
	logic ready;
	logic cmd;
	logic [fipc_pkg::TIME_BITS-1:0] tick_time;
	logic signed [POS_BITS-1:0] pos_x;
	logic signed [POS_BITS-1:0] pos_y;
	logic signed [POS_BITS-1:0] pos_z;
	logic signed [QUAT_BITS-1:0] quat_w;
	logic signed [QUAT_BITS-1:0] quat_x;
	logic signed [QUAT_BITS-1:0] quat_y;
	logic signed [QUAT_BITS-1:0] quat_z;
	modport source (output valid, cmd, tick_time, pos_x, pos_y, pos_z,
		quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, cmd, tick_time, pos_x, pos_y, pos_z,
		quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface fipc_out_if;
	logic valid;
	logic ready;
	logic signed [fipc_pkg::TGT_BITS-1:0] force_x;
	logic signed [fipc_pkg::TGT_BITS-1:0] force_y;
	logic signed [fipc_pkg::TGT_BITS-1:0] force_z;
	logic signed [fipc_pkg::TGT_BITS-1:0] torque_x;
	logic signed [fipc_pkg::TGT_BITS-1:0] torque_y;
	logic signed [fipc_pkg::TGT_BITS-1:0] torque_z;
	logic stopped;
	modport source (output valid, force_x, force_y, force_z, torque_x, torque_y,
		torque_z, stopped, input ready);
	modport sink (input valid, force_x, force_y, force_z, torque_x, torque_y,
		torque_z, stopped, output ready);
endinterface

interface fipc_cfg_if;
	logic valid;
	logic ready;
	logic [fipc_pkg::IDX_BITS-1:0] index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/force_impulse_profile_with_cap_top.sv
// Top level: force/torque impulse profile with displacement cap.
// Capture item: accepted in the idle state, no result.
// Tick item: accept, cap check, on a ramp a division of 48 quotient bits plus a hand-over,
// then scaling of all six axes on one shared 16x17 multiplier, then the result.
// The next item is accepted only after the previous result has been taken.
// Reset (arst_n low): config registers zero, start pose zero with identity quaternion, stop clear.
module force_impulse_profile_with_cap_top #(
	parameter int POS_BITS = fipc_pkg::POS_BITS_DEF,
	parameter int QUAT_BITS = fipc_pkg::QUAT_BITS_DEF,
	parameter int COEF_FRAC_BITS = fipc_pkg::COEF_FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	fipc_in_if.sink in_ch,
	fipc_out_if.source out_ch,
	fipc_cfg_if.sink cfg
);
	fipc_pkg::cmd_t cmd;
	fipc_pkg::status_t sts;
	logic signed [fipc_pkg::TGT_BITS-1:0] res [fipc_pkg::AXES];
	logic stop;

	fipc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(in_ch.valid && in_ch.ready), .in_cmd(in_ch.cmd),
		.out_fire(out_ch.valid && out_ch.ready),
		.sts(sts), .cmd(cmd), .in_ready(in_ch.ready), .out_valid(out_ch.valid)
	);

	fipc_dp #(.POS_BITS(POS_BITS), .QUAT_BITS(QUAT_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS))
	u_dp (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .cfg(cfg),
		.cmd(cmd), .sts(sts), .res_q(res), .stop_q(stop)
	);

	assign out_ch.force_x = res[0];
	assign out_ch.force_y = res[1];
	assign out_ch.force_z = res[2];
	assign out_ch.torque_x = res[3];
	assign out_ch.torque_y = res[4];
	assign out_ch.torque_z = res[5];
	assign out_ch.stopped = stop;
endmodule

// File: hw/rtl/fipc_ctrl.sv
// Controller: sequences capture, cap check, coefficient division and scaling.
module fipc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_cmd,
	input  logic out_fire,
	input  fipc_pkg::status_t sts,
	output fipc_pkg::cmd_t cmd,
	output logic in_ready,
	output logic out_valid
);
	fipc_pkg::state_t state_q, state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= fipc_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fipc_pkg::ST_IDLE: if (in_fire && in_cmd) state_d = fipc_pkg::ST_CHECK;
			fipc_pkg::ST_CHECK: begin
				state_d = fipc_pkg::ST_SCALE;
			end
			fipc_pkg::ST_DIV: if (sts.div_done) state_d = fipc_pkg::ST_SCALE;
			fipc_pkg::ST_SCALE: if (sts.scale_done) state_d = fipc_pkg::ST_OUT;
			fipc_pkg::ST_OUT: if (out_fire) state_d = fipc_pkg::ST_IDLE;
			default: state_d = fipc_pkg::ST_IDLE;
		endcase
		if (state_q == fipc_pkg::ST_CHECK && sts.need_div) state_d = fipc_pkg::ST_DIV;
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			fipc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_fire && !in_cmd;
				cmd.check = in_fire && in_cmd;
			end
			fipc_pkg::ST_CHECK: cmd.div_start = 1'b1;
			fipc_pkg::ST_DIV: cmd.div_step = 1'b1;
			fipc_pkg::ST_SCALE: cmd.scale_step = 1'b1;
			fipc_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_out_only_after_scale: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == fipc_pkg::ST_SCALE)
		else $error("result shown without scaling");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == fipc_pkg::ST_IDLE)
		else $error("input taken while busy");
	a_div_then_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fipc_pkg::ST_DIV && sts.div_done) |=> state_q == fipc_pkg::ST_SCALE)
		else $error("division did not hand over");
`endif
endmodule

// File: hw/rtl/fipc_dp.sv
// Datapath: config registers, start pose, cap checks, divider and shared scaler.
module fipc_dp #(
	parameter int POS_BITS = fipc_pkg::POS_BITS_DEF,
	parameter int QUAT_BITS = fipc_pkg::QUAT_BITS_DEF,
	parameter int COEF_FRAC_BITS = fipc_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fipc_in_if.sink in_ch,
	fipc_cfg_if.sink cfg,
	input  fipc_pkg::cmd_t cmd,
	output fipc_pkg::status_t sts,
	output logic signed [fipc_pkg::TGT_BITS-1:0] res_q [fipc_pkg::AXES],
	output logic stop_q
);
	localparam int TB = fipc_pkg::TIME_BITS;
	localparam int TW = fipc_pkg::TGT_BITS;
	localparam int NUMW = TB + COEF_FRAC_BITS;
	localparam int CW = COEF_FRAC_BITS + 1;
	localparam int DW = POS_BITS + 1;
	localparam int SQW = 2 * DW;
	localparam int DOTW = 2 * QUAT_BITS + 2;
	localparam int CSH = 2 * (QUAT_BITS - 1) - fipc_pkg::COS_BITS;
	localparam int AXW = $clog2(fipc_pkg::AXES + 1);
	localparam int DCW = $clog2(NUMW + 1);

	logic [TB-1:0] run_q, ramp_q;
	logic [fipc_pkg::LIM_BITS-1:0] tlim_q;
	logic [fipc_pkg::COS_BITS-1:0] rcos_q;
	logic [fipc_pkg::PACK_BITS-1:0] frc_q, trq_q;
	logic signed [POS_BITS-1:0] sp_q [3];
	logic signed [QUAT_BITS-1:0] sq_q [4];

	// Write config registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0; ramp_q <= '0; tlim_q <= '0; rcos_q <= '0; frc_q <= '0; trq_q <= '0;
		end else if (cfg.valid) begin
			case (fipc_pkg::reg_idx_t'(cfg.index))
				fipc_pkg::REG_RUN: run_q <= cfg.data[TB-1:0];
				fipc_pkg::REG_RAMP: ramp_q <= cfg.data[TB-1:0];
				fipc_pkg::REG_TLIM: tlim_q <= cfg.data[fipc_pkg::LIM_BITS-1:0];
				fipc_pkg::REG_RCOS: rcos_q <= cfg.data[fipc_pkg::COS_BITS-1:0];
				fipc_pkg::REG_FORCE: frc_q <= cfg.data[fipc_pkg::PACK_BITS-1:0];
				fipc_pkg::REG_TORQUE: trq_q <= cfg.data[fipc_pkg::PACK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Latch tick inputs on accept
	logic signed [DW-1:0] d_s1 [3];
	logic signed [QUAT_BITS-1:0] q_s1 [4];
	logic [TB-1:0] t_s1;
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			d_s1[0] <= DW'(in_ch.pos_x) - DW'(sp_q[0]);
			d_s1[1] <= DW'(in_ch.pos_y) - DW'(sp_q[1]);
			d_s1[2] <= DW'(in_ch.pos_z) - DW'(sp_q[2]);
			q_s1[0] <= in_ch.quat_w; q_s1[1] <= in_ch.quat_x;
			q_s1[2] <= in_ch.quat_y; q_s1[3] <= in_ch.quat_z;
			t_s1 <= in_ch.tick_time;
		end
	end

	// Cap check terms (squares and products at full width)
	logic [SQW+1:0] ssum;
	logic signed [DOTW-1:0] dot;
	logic [DOTW-1:0] dmag;
	logic trip;
	always_comb begin
		ssum = (SQW+2)'($unsigned(SQW'(d_s1[0] * d_s1[0])))
			+ (SQW+2)'($unsigned(SQW'(d_s1[1] * d_s1[1])))
			+ (SQW+2)'($unsigned(SQW'(d_s1[2] * d_s1[2])));
		dot = DOTW'(q_s1[0] * sq_q[0]) + DOTW'(q_s1[1] * sq_q[1])
			+ DOTW'(q_s1[2] * sq_q[2]) + DOTW'(q_s1[3] * sq_q[3]);
		dmag = dot[DOTW-1] ? -dot : dot;
		trip = ((tlim_q != '0) && (66'(ssum) > 66'(tlim_q)))
			|| ((rcos_q != '0) && (66'(dmag) < (66'(rcos_q) << CSH)));
	end

	// Start pose and stop latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q[0] <= '0; sp_q[1] <= '0; sp_q[2] <= '0;
			sq_q[0] <= {1'b0, {(QUAT_BITS-1){1'b1}}};
			sq_q[1] <= '0; sq_q[2] <= '0; sq_q[3] <= '0;
			stop_q <= 1'b0;
		end else if (cmd.capture) begin
			sp_q[0] <= in_ch.pos_x; sp_q[1] <= in_ch.pos_y; sp_q[2] <= in_ch.pos_z;
			sq_q[0] <= in_ch.quat_w; sq_q[1] <= in_ch.quat_x;
			sq_q[2] <= in_ch.quat_y; sq_q[3] <= in_ch.quat_z;
			stop_q <= 1'b0;
		end else if (cmd.div_start && trip) begin
			stop_q <= 1'b1;
		end
	end

	// Profile region select
	logic signed [TB+1:0] ts, rs, ns;
	logic up, flat, down;
	always_comb begin
		ts = (TB+2)'(t_s1);
		rs = (TB+2)'(ramp_q);
		ns = (TB+2)'(run_q);
		up = ts < rs;
		flat = ts < ns - rs;
		down = ts < ns;
	end
	assign sts.need_div = !stop_q && !trip && (up || (!flat && down));

	// Restoring divider, one quotient bit per cycle
	logic [NUMW-1:0] quo_q;
	logic [TB:0] rem_q;
	logic [DCW-1:0] dcnt_q;
	logic [CW-1:0] coef_q;
	logic [TB:0] rtry;
	assign rtry = {rem_q[TB-1:0], quo_q[NUMW-1]};
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			quo_q <= up ? {t_s1, {COEF_FRAC_BITS{1'b0}}}
				: {TB'(run_q - t_s1), {COEF_FRAC_BITS{1'b0}}};
			rem_q <= '0;
			dcnt_q <= '0;
			if (!(stop_q || trip) && !up && flat) coef_q <= CW'(1) << COEF_FRAC_BITS;
			else coef_q <= '0;
		end else if (cmd.div_step) begin
			if (rtry >= {1'b0, ramp_q}) begin
				rem_q <= rtry - {1'b0, ramp_q};
				quo_q <= {quo_q[NUMW-2:0], 1'b1};
			end else begin
				rem_q <= rtry;
				quo_q <= {quo_q[NUMW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + 1'b1;
			if (sts.div_done) coef_q <= CW'(quo_q);
		end
	end
	assign sts.div_done = dcnt_q == DCW'(NUMW);

	// Scale one axis per cycle through a shared multiplier
	logic [AXW-1:0] ax_q;
	logic signed [TW-1:0] tgt;
	logic [TW-1:0] mag;
	logic [TW+CW-1:0] prod;
	logic [TW-1:0] sc;
	always_comb begin
		case (ax_q)
			AXW'(0): tgt = frc_q[15:0];
			AXW'(1): tgt = frc_q[31:16];
			AXW'(2): tgt = frc_q[47:32];
			AXW'(3): tgt = trq_q[15:0];
			AXW'(4): tgt = trq_q[31:16];
			default: tgt = trq_q[47:32];
		endcase
		mag = tgt[TW-1] ? -tgt : tgt;
		prod = (TW+CW)'(mag) * (TW+CW)'(coef_q);
		sc = TW'(prod >> COEF_FRAC_BITS);
		if (tgt[TW-1]) sc = -sc;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ax_q <= '0;
		else if (cmd.scale_step) ax_q <= sts.scale_done ? '0 : ax_q + 1'b1;
	end
	always_ff @(posedge clk) begin
		if (cmd.scale_step && !sts.scale_done) res_q[ax_q[2:0]] <= sc;
	end
	assign sts.scale_done = ax_q == AXW'(fipc_pkg::AXES);

`ifndef SYNTHESIS
	a_stop_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !stop_q)
		else $error("capture did not clear stop");
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(stop_q && !cmd.capture) |=> stop_q)
		else $error("stop latch dropped");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> dcnt_q <= DCW'(NUMW))
		else $error("divider overran");
`endif
endmodule

// File: tb/tb_fipc_chan.sv
// Testbench helper: nothing beyond the RTL interfaces is needed; this file holds shared tb types.
`timescale 1ns / 100ps
package tb_fipc_pkg;
	typedef struct packed {
		logic cmd;
		logic [31:0] tick_time;
		logic signed [23:0] pos_x, pos_y, pos_z;
		logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
	} pose_item_t;

	typedef struct packed {
		logic signed [15:0] force_x, force_y, force_z;
		logic signed [15:0] torque_x, torque_y, torque_z;
		logic stopped;
	} wrench_t;
endpackage

// File: tb/tb.sv
// Testbench top: drives pose items and register writes, checks wrench outputs against a predictor.
`timescale 1ns / 100ps
module tb;
	logic clk;
	logic arst_n;
	fipc_in_if in_ch();
	fipc_out_if out_ch();
	fipc_cfg_if cfg();

	force_impulse_profile_with_cap_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	// predictor state
	logic [31:0] run_len, ramp_len;
	logic [51:0] tlim_sq;
	logic [14:0] cos_lim;
	logic [47:0] force_pack, torque_pack;
	logic signed [23:0] home_x, home_y, home_z;
	logic signed [15:0] home_q [4];
	logic stop_flag;

	tb_fipc_pkg::wrench_t wrench_q[$];
	int errors;
	int rx_mode;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [63:0] sq_mag(longint d);
		longint unsigned m;
		m = d < 0 ? -d : d;
		return m * m;
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = a + b;
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	function automatic logic [63:0] ramp_coef(logic [31:0] t);
		longint ts, run, ramp;
		ts = longint'({32'd0, t});
		run = longint'({32'd0, run_len});
		ramp = longint'({32'd0, ramp_len});
		if (ts < ramp) return ({32'd0, t} << 16) / {32'd0, ramp_len};
		if (ts < run - ramp) return 64'd65536;
		if (ts < run) return (64'(run - ts) << 16) / {32'd0, ramp_len};
		return 64'd0;
	endfunction

	function automatic logic [15:0] scale_lane(logic [63:0] coef, logic [47:0] pack, int lane);
		logic signed [15:0] tgt;
		logic [63:0] mag, r;
		tgt = pack[16*lane +: 16];
		mag = tgt < 0 ? 64'(-32'(tgt)) : 64'(tgt);
		r = (mag * coef) >> 16;
		if (tgt < 0) r = -r;
		return r[15:0];
	endfunction

	// advance predictor by one item; push expected wrench for ticks
	task automatic predict_wrench(tb_fipc_pkg::pose_item_t it);
		logic [63:0] s, coef;
		longint dot;
		logic [63:0] dmag;
		tb_fipc_pkg::wrench_t w;
		if (!it.cmd) begin
			home_x = it.pos_x; home_y = it.pos_y; home_z = it.pos_z;
			home_q[0] = it.quat_w; home_q[1] = it.quat_x;
			home_q[2] = it.quat_y; home_q[3] = it.quat_z;
			stop_flag = 1'b0;
			return;
		end
		if (!stop_flag) begin
			if (tlim_sq != 0) begin
				s = sq_mag(longint'(it.pos_x) - home_x);
				s = add_sat(s, sq_mag(longint'(it.pos_y) - home_y));
				s = add_sat(s, sq_mag(longint'(it.pos_z) - home_z));
				if (s > {12'd0, tlim_sq}) stop_flag = 1'b1;
			end
			if (cos_lim != 0) begin
				dot = longint'(it.quat_w) * home_q[0] + longint'(it.quat_x) * home_q[1]
					+ longint'(it.quat_y) * home_q[2] + longint'(it.quat_z) * home_q[3];
				dmag = dot < 0 ? -dot : dot;
				if (dmag < ({49'd0, cos_lim} << 15)) stop_flag = 1'b1;
			end
		end
		coef = stop_flag ? 64'd0 : ramp_coef(it.tick_time);
		w.force_x = scale_lane(coef, force_pack, 0);
		w.force_y = scale_lane(coef, force_pack, 1);
		w.force_z = scale_lane(coef, force_pack, 2);
		w.torque_x = scale_lane(coef, torque_pack, 0);
		w.torque_y = scale_lane(coef, torque_pack, 1);
		w.torque_z = scale_lane(coef, torque_pack, 2);
		w.stopped = stop_flag;
		wrench_q.push_back(w);
	endtask

	task automatic write_reg(fipc_pkg::reg_idx_t idx, logic [63:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		case (idx)
			fipc_pkg::REG_RUN: run_len = val[31:0];
			fipc_pkg::REG_RAMP: ramp_len = val[31:0];
			fipc_pkg::REG_TLIM: tlim_sq = val[51:0];
			fipc_pkg::REG_RCOS: cos_lim = val[14:0];
			fipc_pkg::REG_FORCE: force_pack = val[47:0];
			fipc_pkg::REG_TORQUE: torque_pack = val[47:0];
			default: ;
		endcase
	endtask

	// wait until no result is outstanding, then let a busy block finish
	task automatic drain_block();
		while (wrench_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_item(tb_fipc_pkg::pose_item_t it);
		in_ch.valid <= 1'b1;
		in_ch.cmd <= it.cmd;
		in_ch.tick_time <= it.tick_time;
		in_ch.pos_x <= it.pos_x; in_ch.pos_y <= it.pos_y; in_ch.pos_z <= it.pos_z;
		in_ch.quat_w <= it.quat_w; in_ch.quat_x <= it.quat_x;
		in_ch.quat_y <= it.quat_y; in_ch.quat_z <= it.quat_z;
		do @(posedge clk); while (!in_ch.ready);
		predict_wrench(it);
	endtask

	// drop valid for a random idle gap
	task automatic idle_gap();
		int n;
		in_ch.valid <= 1'b0;
		n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(2, 12)) : 1;
		repeat (n) @(posedge clk);
	endtask

	function automatic tb_fipc_pkg::pose_item_t rand_item(int near);
		tb_fipc_pkg::pose_item_t it;
		it.cmd = $urandom_range(0, 5) != 0;
		if ($urandom_range(0, 1)) it.tick_time = 32'($urandom_range(0, 80));
		else it.tick_time = 32'($urandom);
		if (near) begin
			it.pos_x = home_x + $signed(24'($urandom_range(0, 200)) - 24'd100);
			it.pos_y = home_y + $signed(24'($urandom_range(0, 200)) - 24'd100);
			it.pos_z = home_z + $signed(24'($urandom_range(0, 200)) - 24'd100);
			it.quat_w = home_q[0] + $signed(16'($urandom_range(0, 4000)) - 16'd2000);
			it.quat_x = home_q[1] + $signed(16'($urandom_range(0, 4000)) - 16'd2000);
			it.quat_y = home_q[2];
			it.quat_z = home_q[3];
		end else begin
			it.pos_x = 24'($urandom); it.pos_y = 24'($urandom); it.pos_z = 24'($urandom);
			it.quat_w = 16'($urandom); it.quat_x = 16'($urandom);
			it.quat_y = 16'($urandom); it.quat_z = 16'($urandom);
		end
		return it;
	endfunction

	// result checker
	always @(posedge clk) begin
		tb_fipc_pkg::wrench_t got, exp_w;
		if (out_ch.valid && out_ch.ready) begin
			got = {out_ch.force_x, out_ch.force_y, out_ch.force_z, out_ch.torque_x,
				out_ch.torque_y, out_ch.torque_z, out_ch.stopped};
			if (wrench_q.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
			end else begin
				exp_w = wrench_q.pop_front();
				if (got !== exp_w) begin
					$display("%0t: expected %h actual %h", $realtime, exp_w, got);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= $urandom_range(0, 1);
				default: out_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	typedef struct {
		tb_fipc_pkg::pose_item_t it;
		bit has_exp;
		tb_fipc_pkg::wrench_t w;
	} dir_row_t;

	initial begin
		dir_row_t rows[$];
		dir_row_t r;
		tb_fipc_pkg::pose_item_t it;
		logic [63:0] cfg_set [6];
		errors = 0;
		rx_mode = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0; in_ch.cmd = 1'b0; in_ch.tick_time = '0;
		in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
		in_ch.quat_w = '0; in_ch.quat_x = '0; in_ch.quat_y = '0; in_ch.quat_z = '0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		run_len = '0; ramp_len = '0; tlim_sq = '0; cos_lim = '0;
		force_pack = '0; torque_pack = '0;
		home_x = '0; home_y = '0; home_z = '0;
		home_q[0] = 16'sd32767; home_q[1] = '0; home_q[2] = '0; home_q[3] = '0;
		stop_flag = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: after reset all targets zero, zero run gives zero output
		r.it = '{cmd: 1'b1, tick_time: 32'd0, default: '0};
		r.has_exp = 1; r.w = '0;
		rows.push_back(r);
		r.it = '{cmd: 1'b1, tick_time: 32'hFFFF_FFFF, default: '0};
		rows.push_back(r);
		foreach (rows[i]) begin
			tb_fipc_pkg::wrench_t pre;
			send_item(rows[i].it);
			pre = wrench_q[$];
			if (rows[i].has_exp && pre !== rows[i].w) begin
				$display("%0t: expected %h actual %h (predictor)", $realtime, rows[i].w, pre);
				errors++;
			end
		end
		in_ch.valid <= 1'b0;
		drain_block();

		// extremes: step profile with full-scale targets
		write_reg(fipc_pkg::REG_RUN, 64'd10);
		write_reg(fipc_pkg::REG_RAMP, 64'd0);
		write_reg(fipc_pkg::REG_FORCE, {16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF});
		write_reg(fipc_pkg::REG_TORQUE, {16'h0000, 16'h0001, 16'h8001, 16'h7FFF});
		write_reg(fipc_pkg::REG_TLIM, 64'hF_FFFF_FFFF_FFFF);
		write_reg(fipc_pkg::REG_RCOS, 64'h7FFF);
		rows.delete();
		r.has_exp = 0;
		// capture extreme pose, then ticks: exact match, step, end, far jumps
		r.it = '{cmd: 1'b0, tick_time: 0, pos_x: 24'sh7FFFFF, pos_y: 24'sh800000,
			pos_z: 0, quat_w: 16'sh7FFF, quat_x: 0, quat_y: 0, quat_z: 0};
		rows.push_back(r);
		r.it.cmd = 1; r.it.tick_time = 9; rows.push_back(r);
		r.it.tick_time = 10; rows.push_back(r);
		r.it.pos_x = 24'sh800000; r.it.pos_y = 24'sh7FFFFF; r.it.tick_time = 3;
		rows.push_back(r);
		// rotation cap: opposite quaternion is fine, orthogonal latches
		r.it = '{cmd: 1'b0, default: '0}; r.it.quat_w = 16'sh8000; rows.push_back(r);
		r.it.cmd = 1; r.it.quat_w = 16'sh7FFF; rows.push_back(r);
		r.it.quat_w = 0; r.it.quat_x = 16'sh7FFF; rows.push_back(r);
		r.it.quat_w = 16'sh8000; r.it.quat_x = 0; rows.push_back(r);
		r.it.cmd = 0; rows.push_back(r);
		r.it.cmd = 1; r.it.quat_x = 16'sh7FFF; r.it.quat_y = 16'sh8000;
		r.it.quat_z = 16'sh7FFF; r.it.tick_time = 32'h8000_0000; rows.push_back(r);
		foreach (rows[i]) send_item(rows[i].it);
		in_ch.valid <= 1'b0;
		drain_block();

		// short run with ramp, caps off
		write_reg(fipc_pkg::REG_RUN, 64'd5);
		write_reg(fipc_pkg::REG_RAMP, 64'd4);
		write_reg(fipc_pkg::REG_TLIM, 64'd0);
		write_reg(fipc_pkg::REG_RCOS, 64'd0);
		for (int t = 0; t < 10; t++) begin
			it = '{cmd: 1'b1, default: '0};
			it.tick_time = 32'(t);
			send_item(it);
		end
		it.tick_time = 32'hFFFF_FFFF; send_item(it);
		in_ch.valid <= 1'b0;
		drain_block();

		// random phases with varied settings
		for (int ph = 0; ph < 12; ph++) begin
			rx_mode = ph % 3;
			case (ph % 4)
				0: begin
					cfg_set[0] = 64'($urandom_range(10, 80));
					cfg_set[1] = 64'($urandom_range(0, 20));
				end
				1: begin cfg_set[0] = 64'($urandom); cfg_set[1] = 64'($urandom); end
				2: begin cfg_set[0] = 64'hFFFF_FFFF; cfg_set[1] = 64'hFFFF_FFFF; end
				default: begin cfg_set[0] = 64'($urandom_range(0, 30)); cfg_set[1] = 64'd1; end
			endcase
			cfg_set[2] = ($urandom_range(0, 2) == 0) ? 64'd0 :
				(($urandom_range(0, 1)) ? {$urandom, $urandom} : 64'($urandom_range(1, 30000)));
			cfg_set[3] = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom_range(1, 32767));
			cfg_set[4] = {$urandom, $urandom};
			cfg_set[5] = {$urandom, $urandom};
			for (int k = 0; k < 6; k++) write_reg(fipc_pkg::reg_idx_t'(k), cfg_set[k]);
			for (int n = 0; n < 105; n++) begin
				it = rand_item($urandom_range(0, 9) != 0);
				send_item(it);
				if ($urandom_range(0, 4) == 0) idle_gap();
			end
			in_ch.valid <= 1'b0;
			drain_block();
		end

		while (wrench_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
